// ----- hw/rtl/fpgt_pkg.sv -----
// ----------------------------------------------------------------------------
// fpgt_pkg
// Shared widths, action and motion codes, register indexes and reset values
// for the fall posture get-up trigger.
// ----------------------------------------------------------------------------
package fpgt_pkg;

    localparam int TIME_W     = 32;
    localparam int ACTION_W   = 2;
    localparam int KIND_W     = 2;
    localparam int SLOT_W     = 8;
    localparam int OFFSET_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int WINDOW_W = 8;
    localparam int SMP_INT_W = 16;
    localparam int GRAV_W   = 15;
    localparam int BASE_W   = 24;

    // input action codes
    localparam logic [ACTION_W-1:0] ACT_SAMPLE   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_TICK     = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_ACTIVITY = 2'd2;

    // requested motion kinds
    localparam logic [KIND_W-1:0] KIND_FACE_DOWN = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FACE_UP   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RANDOM    = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SMP_INT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_INT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_SWAP  = 3'd4;

    // register reset values
    localparam logic [WINDOW_W-1:0]  WINDOW_RST  = 8'd10;
    localparam logic [SMP_INT_W-1:0] SMP_INT_RST = 16'd100;
    localparam logic [GRAV_W-1:0]    GRAV_RST    = 15'd8000;
    localparam logic [BASE_W-1:0]    BASE_RST    = 24'd15000;

endpackage

// ----- hw/rtl/fpgt_in_if.sv -----
// ----------------------------------------------------------------------------
// fpgt_in_if
// Input channel: one sample, tick or activity event per transfer.
// ----------------------------------------------------------------------------
interface fpgt_in_if
    import fpgt_pkg::*;
#(
    parameter int ACC_BITS = 16
) ();
    logic                        valid;
    logic                        ready;
    logic [ACTION_W-1:0]         action;
    logic [TIME_W-1:0]           now_ms;
    logic signed [ACC_BITS-1:0]  acc_x;
    logic signed [ACC_BITS-1:0]  acc_y;
    logic signed [ACC_BITS-1:0]  acc_z;
    logic                        motion_playing;
    logic                        serial_pending;
    logic [OFFSET_W-1:0]         random_offset;
    logic [SLOT_W-1:0]           random_slot;

    modport source (
        output valid, action, now_ms, acc_x, acc_y, acc_z,
               motion_playing, serial_pending, random_offset, random_slot,
        input  ready
    );
    modport sink (
        input  valid, action, now_ms, acc_x, acc_y, acc_z,
               motion_playing, serial_pending, random_offset, random_slot,
        output ready
    );
endinterface

// ----- hw/rtl/fpgt_out_if.sv -----
// ----------------------------------------------------------------------------
// fpgt_out_if
// Output channel: one motion request / lying status per transfer.
// ----------------------------------------------------------------------------
interface fpgt_out_if
    import fpgt_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              play_valid;
    logic [KIND_W-1:0] play_kind;
    logic [SLOT_W-1:0] motion_slot;
    logic              lying;

    modport source (
        output valid, play_valid, play_kind, motion_slot, lying,
        input  ready
    );
    modport sink (
        input  valid, play_valid, play_kind, motion_slot, lying,
        output ready
    );
endinterface

// ----- hw/rtl/fall_posture_getup_trigger.sv -----
// ----------------------------------------------------------------------------
// fall_posture_getup_trigger
// Accumulates accelerometer samples, detects a lying posture from the window
// average and requests get-up or random idle motions on action ticks.
// ----------------------------------------------------------------------------
// Every input transfer yields exactly one output transfer. Ticks, activity
// events and samples that do not close a window go through the accept step,
// then the load of the output register. A sample that closes the averaging
// window also passes a load, divide and store step per axis: the three axis
// sums are divided one after another by a single restoring divider that
// retires one quotient bit per cycle, and a lying decision step follows the
// last axis. The input is not ready while an item is in progress or while
// its result waits behind an untaken output. Configuration writes are taken
// in any cycle but are meant for idle time.
module fall_posture_getup_trigger
    import fpgt_pkg::*;
#(
    parameter int ACC_BITS = 16,
    parameter int SUM_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    fpgt_in_if.sink               i_in,
    fpgt_out_if.source            o_out
);

    localparam int STEP_W = $clog2(SUM_BITS);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_BITS - 1);
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_DIV,
        S_STORE,
        S_DECIDE,
        S_PUSH
    } t_state;

    typedef logic signed [SUM_BITS-1:0] t_sum;

    // configuration
    logic [WINDOW_W-1:0]  r_window,  n_window;
    logic [SMP_INT_W-1:0] r_smp_int, n_smp_int;
    logic [GRAV_W-1:0]    r_grav,    n_grav;
    logic [BASE_W-1:0]    r_base,    n_base;
    logic                 r_swap,    n_swap;

    // block state
    t_sum                 r_sum  [3];
    t_sum                 n_sum  [3];
    logic [SUM_BITS-1:0]  r_qmag [3];
    logic [SUM_BITS-1:0]  n_qmag [3];
    logic [WINDOW_W-1:0]  r_count, n_count;
    logic [TIME_W-1:0]    r_next,  n_next;
    logic [TIME_W-1:0]    r_last,  n_last;
    logic [TIME_W-1:0]    r_idle,  n_idle;
    logic                 r_lying, n_lying;

    // sequencer and divider
    t_state               r_state, n_state;
    logic [1:0]           r_axis,  n_axis;
    logic [STEP_W-1:0]    r_step,  n_step;
    logic [SUM_BITS-1:0]  r_dvd,   n_dvd;
    logic [WINDOW_W-1:0]  r_rem,   n_rem;
    logic [WINDOW_W-1:0]  r_dsr,   n_dsr;
    logic                 r_neg,   n_neg;

    // pending result and output register
    logic                 r_res_play, n_res_play;
    logic [KIND_W-1:0]    r_res_kind, n_res_kind;
    logic [SLOT_W-1:0]    r_res_slot, n_res_slot;
    logic                 r_out_valid, n_out_valid;
    logic                 r_out_play,  n_out_play;
    logic [KIND_W-1:0]    r_out_kind,  n_out_kind;
    logic [SLOT_W-1:0]    r_out_slot,  n_out_slot;
    logic                 r_out_lying, n_out_lying;

    logic                 in_fire;
    logic signed [ACC_BITS-1:0] in_acc_x, in_acc_y, in_acc_z;
    logic [SUM_BITS-1:0]  neg_in, neg_out;
    logic [WINDOW_W:0]    trial, diff;
    logic                 trial_ge;
    logic [WINDOW_W-1:0]  cnt_inc, win_eff;

    assign i_in.ready = (r_state == S_IDLE);
    assign in_fire    = i_in.valid && (r_state == S_IDLE);

    assign in_acc_x = i_in.acc_x;
    assign in_acc_y = i_in.acc_y;
    assign in_acc_z = i_in.acc_z;

    // shared negator: magnitude on load, sign restore on store
    assign neg_in  = (r_state == S_LOAD) ? r_sum[r_axis] : r_dvd;
    assign neg_out = -neg_in;

    // restoring divider step, quotient shifts into the dividend register
    assign trial    = {r_rem, r_dvd[SUM_BITS-1]};
    assign trial_ge = (trial >= {1'b0, r_dsr});
    assign diff     = trial - {1'b0, r_dsr};

    assign cnt_inc = r_count + 1'b1;
    assign win_eff = (r_window == '0) ? WINDOW_W'(1) : r_window;

    always_comb begin
        n_window    = r_window;
        n_smp_int   = r_smp_int;
        n_grav      = r_grav;
        n_base      = r_base;
        n_swap      = r_swap;
        n_sum       = r_sum;
        n_qmag      = r_qmag;
        n_count     = r_count;
        n_next      = r_next;
        n_last      = r_last;
        n_idle      = r_idle;
        n_lying     = r_lying;
        n_state     = r_state;
        n_axis      = r_axis;
        n_step      = r_step;
        n_dvd       = r_dvd;
        n_rem       = r_rem;
        n_dsr       = r_dsr;
        n_neg       = r_neg;
        n_res_play  = r_res_play;
        n_res_kind  = r_res_kind;
        n_res_slot  = r_res_slot;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_play  = r_out_play;
        n_out_kind  = r_out_kind;
        n_out_slot  = r_out_slot;
        n_out_lying = r_out_lying;

        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WINDOW:   n_window  = i_cfg_data[WINDOW_W-1:0];
                CFG_SMP_INT:  n_smp_int = i_cfg_data[SMP_INT_W-1:0];
                CFG_GRAVITY:  n_grav    = i_cfg_data[GRAV_W-1:0];
                CFG_BASE_INT: n_base    = i_cfg_data[BASE_W-1:0];
                CFG_DIR_SWAP: n_swap    = i_cfg_data[0];
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_res_play = 1'b0;
                    n_res_kind = KIND_FACE_DOWN;
                    n_res_slot = '0;
                    n_state    = S_PUSH;
                    case (i_in.action)
                        ACT_SAMPLE: begin
                            if (!i_in.motion_playing && !i_in.serial_pending &&
                                !(i_in.now_ms < r_next)) begin
                                n_sum[0] = r_sum[0] + SUM_BITS'(in_acc_x);
                                n_sum[1] = r_sum[1] + SUM_BITS'(in_acc_y);
                                n_sum[2] = r_sum[2] + SUM_BITS'(in_acc_z);
                                n_next   = r_next + TIME_W'(r_smp_int);
                                if (cnt_inc >= win_eff) begin
                                    n_dsr   = cnt_inc;
                                    n_count = '0;
                                    n_axis  = AXIS_X;
                                    n_state = S_LOAD;
                                end else begin
                                    n_count = cnt_inc;
                                end
                            end
                        end
                        ACT_TICK: begin
                            if (r_lying) begin
                                n_res_play = 1'b1;
                                n_res_kind = (~r_sum[1][SUM_BITS-1] ^ r_swap) ?
                                             KIND_FACE_UP : KIND_FACE_DOWN;
                                n_lying    = 1'b0;
                                n_sum[0]   = '0;
                                n_sum[1]   = '0;
                                n_sum[2]   = '0;
                            end else if ((i_in.now_ms - r_last) > r_idle) begin
                                n_res_play = 1'b1;
                                n_res_kind = KIND_RANDOM;
                                n_res_slot = i_in.random_slot;
                                n_last     = i_in.now_ms;
                                n_idle     = TIME_W'(r_base) + TIME_W'(i_in.random_offset);
                            end
                        end
                        ACT_ACTIVITY: begin
                            n_last = i_in.now_ms;
                        end
                        default: ;
                    endcase
                end
            end
            S_LOAD: begin
                n_neg   = r_sum[r_axis][SUM_BITS-1];
                n_dvd   = r_sum[r_axis][SUM_BITS-1] ? neg_out : r_sum[r_axis];
                n_rem   = '0;
                n_step  = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_rem  = trial_ge ? diff[WINDOW_W-1:0] : trial[WINDOW_W-1:0];
                n_dvd  = {r_dvd[SUM_BITS-2:0], trial_ge};
                n_step = r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    n_state = S_STORE;
                end
            end
            S_STORE: begin
                n_sum[r_axis]  = r_neg ? neg_out : r_dvd;
                n_qmag[r_axis] = r_dvd;
                if (r_axis == AXIS_Z) begin
                    n_state = S_DECIDE;
                end else begin
                    n_axis  = r_axis + 1'b1;
                    n_state = S_LOAD;
                end
            end
            S_DECIDE: begin
                // quotient magnitudes equal the magnitudes of the averaged sums
                if (r_qmag[AXIS_Y] > r_qmag[AXIS_X] && r_qmag[AXIS_Y] > r_qmag[AXIS_Z] &&
                    r_qmag[AXIS_Y] > SUM_BITS'(r_grav)) begin
                    n_lying = 1'b1;
                end else begin
                    n_sum[0] = '0;
                    n_sum[1] = '0;
                    n_sum[2] = '0;
                end
                n_state = S_PUSH;
            end
            S_PUSH: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_play  = r_res_play;
                    n_out_kind  = r_res_kind;
                    n_out_slot  = r_res_slot;
                    n_out_lying = r_lying;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= WINDOW_RST;
            r_smp_int   <= SMP_INT_RST;
            r_grav      <= GRAV_RST;
            r_base      <= BASE_RST;
            r_swap      <= 1'b0;
            r_sum[0]    <= '0;
            r_sum[1]    <= '0;
            r_sum[2]    <= '0;
            r_count     <= '0;
            r_next      <= TIME_W'(SMP_INT_RST);
            r_last      <= '0;
            r_idle      <= TIME_W'(BASE_RST);
            r_lying     <= 1'b0;
            r_state     <= S_IDLE;
            r_axis      <= AXIS_X;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_window    <= n_window;
            r_smp_int   <= n_smp_int;
            r_grav      <= n_grav;
            r_base      <= n_base;
            r_swap      <= n_swap;
            r_sum       <= n_sum;
            r_count     <= n_count;
            r_next      <= n_next;
            r_last      <= n_last;
            r_idle      <= n_idle;
            r_lying     <= n_lying;
            r_state     <= n_state;
            r_axis      <= n_axis;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
        r_qmag      <= n_qmag;
        r_dvd       <= n_dvd;
        r_rem       <= n_rem;
        r_dsr       <= n_dsr;
        r_neg       <= n_neg;
        r_res_play  <= n_res_play;
        r_res_kind  <= n_res_kind;
        r_res_slot  <= n_res_slot;
        r_out_play  <= n_out_play;
        r_out_kind  <= n_out_kind;
        r_out_slot  <= n_out_slot;
        r_out_lying <= n_out_lying;
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.play_valid  = r_out_play;
    assign o_out.play_kind   = r_out_kind;
    assign o_out.motion_slot = r_out_slot;
    assign o_out.lying       = r_out_lying;

    // a motion request always leaves the lying flag cleared
    a_play_not_lying: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.play_valid |-> !o_out.lying)
        else $error("motion request reported with lying set");

    // no request means zero kind and slot
    a_idle_payload_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.play_valid |-> o_out.play_kind == KIND_FACE_DOWN &&
        o_out.motion_slot == '0)
        else $error("nonzero kind or slot without a motion request");

    // divisor is the nonzero window count and the count restarts at zero
    a_div_setup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_dsr != '0 && r_count == '0)
        else $error("divider running with bad divisor or count");

    // a window pass ends in the decision after the last axis store
    a_store_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_STORE && r_axis == AXIS_Z |=> r_state == S_DECIDE)
        else $error("axis sequencing out of order");

endmodule

// ----- test/fall_posture_getup_trigger_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fall_posture_getup_trigger_tb
// Drives samples, action ticks and activity events into the get-up trigger
// under several register settings and handshake idle patterns. A built-in
// predictor tracks the axis sums, lying flag and idle timer, and every output
// transfer is checked field by field against the oldest predicted request.
// ----------------------------------------------------------------------------
module fall_posture_getup_trigger_tb;
    import fpgt_pkg::*;

    localparam int ACC_W = 16;
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    localparam int NUM_PHASES = 8;
    localparam int unsigned PH_WIN   [NUM_PHASES] = '{10, 1, 255, 4, 2, 7, 3, 16};
    localparam int unsigned PH_SMP   [NUM_PHASES] = '{100, 1, 1, 65535, 37, 1000, 250, 10};
    localparam int unsigned PH_GRAV  [NUM_PHASES] = '{8000, 0, 4000, 16000, 12000, 32767,
                                                      20000, 1000};
    localparam int unsigned PH_BASE  [NUM_PHASES] = '{15000, 0, 2000, 16777215, 500, 40000,
                                                      3000, 100};
    localparam int unsigned PH_SWAP  [NUM_PHASES] = '{0, 1, 0, 0, 1, 1, 0, 1};
    localparam int unsigned PH_ITEMS [NUM_PHASES] = '{170, 170, 300, 170, 170, 170, 170, 170};

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [TIME_W-1:0]   now_ms;
        logic [ACC_W-1:0]    acc_x;
        logic [ACC_W-1:0]    acc_y;
        logic [ACC_W-1:0]    acc_z;
        logic                motion_playing;
        logic                serial_pending;
        logic [OFFSET_W-1:0] random_offset;
        logic [SLOT_W-1:0]   random_slot;
    } t_stim;

    typedef struct packed {
        logic              play;
        logic [KIND_W-1:0] kind;
        logic [SLOT_W-1:0] slot;
        logic              lying;
    } t_motion_req;

    typedef enum int {POS_UPRIGHT, POS_FACE_DN, POS_FACE_UP, POS_NOISE} t_posture;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    fpgt_in_if #(.ACC_BITS(ACC_W)) in_ch ();
    fpgt_out_if                    out_ch ();

    fall_posture_getup_trigger #(
        .ACC_BITS(ACC_W),
        .SUM_BITS(32)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_in      (in_ch),
        .o_out     (out_ch)
    );

    always #5 i_clk = ~i_clk;

    // register shadow
    logic [WINDOW_W-1:0]  cfg_window;
    logic [SMP_INT_W-1:0] cfg_smp_int;
    logic [GRAV_W-1:0]    cfg_grav;
    logic [BASE_W-1:0]    cfg_base;
    logic                 cfg_swap;

    // posture state
    logic signed [31:0] acc_sum [3];
    logic [7:0]         smp_cnt;
    logic [31:0]        next_smp_ms;
    logic [31:0]        last_act_ms;
    logic [31:0]        idle_ms;
    logic               lying_q;

    t_stim       stim_q [$];
    t_motion_req motion_req_q [$];

    int unsigned n_queued       = 0;
    int unsigned n_accepted     = 0;
    int unsigned n_results      = 0;
    int unsigned n_err          = 0;
    int unsigned n_smp_taken    = 0;
    int unsigned n_lying        = 0;
    int unsigned n_getup        = 0;
    int unsigned n_random       = 0;
    int unsigned n_settings     = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    bit          in_taken = 1'b0;
    logic [31:0] t_cursor = '0;
    t_posture    posture  = POS_UPRIGHT;
    t_stim       drv_item;
    t_stim       mon_item;
    t_motion_req got_req;
    t_motion_req want_req;

    function automatic longint mag(logic signed [31:0] v);
        return (v < 0) ? -longint'(v) : longint'(v);
    endfunction

    function automatic void clear_sums();
        acc_sum[0] = '0;
        acc_sum[1] = '0;
        acc_sum[2] = '0;
    endfunction

    function automatic void reset_posture_model();
        cfg_window  = WINDOW_RST;
        cfg_smp_int = SMP_INT_RST;
        cfg_grav    = GRAV_RST;
        cfg_base    = BASE_RST;
        cfg_swap    = 1'b0;
        clear_sums();
        smp_cnt     = '0;
        next_smp_ms = 32'(SMP_INT_RST);
        last_act_ms = '0;
        idle_ms     = 32'(BASE_RST);
        lying_q     = 1'b0;
    endfunction

    function automatic t_motion_req predict_motion_request(t_stim s);
        t_motion_req r;
        logic [7:0]  win;
        logic [31:0] idle_gap;
        longint      q;
        longint      mx;
        longint      my;
        longint      mz;
        r = '0;
        case (s.action)
            ACT_SAMPLE: begin
                if (!s.motion_playing && !s.serial_pending && s.now_ms >= next_smp_ms) begin
                    win = (cfg_window == 0) ? 8'd1 : cfg_window;
                    acc_sum[0] = acc_sum[0] + 32'($signed(s.acc_x));
                    acc_sum[1] = acc_sum[1] + 32'($signed(s.acc_y));
                    acc_sum[2] = acc_sum[2] + 32'($signed(s.acc_z));
                    next_smp_ms = next_smp_ms + 32'(cfg_smp_int);
                    smp_cnt = smp_cnt + 8'd1;
                    n_smp_taken++;
                    if (smp_cnt >= win) begin
                        // signed divide truncates toward zero
                        for (int i = 0; i < 3; i++) begin
                            q = longint'(acc_sum[i]) / longint'(smp_cnt);
                            acc_sum[i] = q[31:0];
                        end
                        mx = mag(acc_sum[0]);
                        my = mag(acc_sum[1]);
                        mz = mag(acc_sum[2]);
                        if (my > mx && my > mz && my > longint'(cfg_grav)) begin
                            lying_q = 1'b1;
                            n_lying++;
                        end else begin
                            clear_sums();
                        end
                        smp_cnt = '0;
                    end
                end
            end
            ACT_TICK: begin
                idle_gap = s.now_ms - last_act_ms;
                if (lying_q) begin
                    r.play = 1'b1;
                    r.kind = ((acc_sum[1] < 0) ^ cfg_swap) ? KIND_FACE_DOWN : KIND_FACE_UP;
                    lying_q = 1'b0;
                    clear_sums();
                    n_getup++;
                end else if (idle_gap > idle_ms) begin
                    r.play = 1'b1;
                    r.kind = KIND_RANDOM;
                    r.slot = s.random_slot;
                    last_act_ms = s.now_ms;
                    idle_ms = 32'(cfg_base) + 32'(s.random_offset);
                    n_random++;
                end
            end
            ACT_ACTIVITY: last_act_ms = s.now_ms;
            default: ;
        endcase
        r.lying = lying_q;
        return r;
    endfunction

    function automatic t_stim mk_stim(logic [ACTION_W-1:0] act, logic [31:0] now,
                                      int x, int y, int z, bit mp, bit sp,
                                      int unsigned off, int unsigned slot);
        t_stim s;
        s.action         = act;
        s.now_ms         = now;
        s.acc_x          = ACC_W'(x);
        s.acc_y          = ACC_W'(y);
        s.acc_z          = ACC_W'(z);
        s.motion_playing = mp;
        s.serial_pending = sp;
        s.random_offset  = OFFSET_W'(off);
        s.random_slot    = SLOT_W'(slot);
        return s;
    endfunction

    function automatic logic signed [ACC_W-1:0] rand_acc(int unsigned lo, int unsigned hi,
                                                         bit neg);
        logic signed [ACC_W-1:0] v;
        v = ACC_W'($urandom_range(hi, lo));
        return neg ? -v : v;
    endfunction

    task automatic push_stim(t_stim s);
        stim_q.push_back(s);
        n_queued++;
    endtask

    // block until every transfer has produced its result, then a short guard
    task automatic wait_quiet();
        while (n_accepted != n_queued || motion_req_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_DATA_W'(val);
        case (idx)
            CFG_WINDOW:   cfg_window  = WINDOW_W'(val);
            CFG_SMP_INT:  cfg_smp_int = SMP_INT_W'(val);
            CFG_GRAVITY:  cfg_grav    = GRAV_W'(val);
            CFG_BASE_INT: cfg_base    = BASE_W'(val);
            CFG_DIR_SWAP: cfg_swap    = val[0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(int unsigned win, int unsigned smp, int unsigned grav,
                                  int unsigned base, int unsigned swap);
        wait_quiet();
        write_reg(CFG_WINDOW, win);
        write_reg(CFG_SMP_INT, smp);
        write_reg(CFG_GRAVITY, grav);
        write_reg(CFG_BASE_INT, base);
        write_reg(CFG_DIR_SWAP, swap);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    task automatic gen_phase(int unsigned n_items);
        t_stim       s;
        int unsigned r;
        int unsigned win_eff;
        int unsigned big_lo;
        win_eff = (cfg_window == 0) ? 1 : cfg_window;
        big_lo  = (cfg_grav > 28000) ? 28000 : cfg_grav - cfg_grav / 8;
        for (int n = 0; n < n_items; n++) begin
            s.motion_playing = ($urandom_range(9) == 0);
            s.serial_pending = ($urandom_range(9) == 0);
            s.random_offset  = OFFSET_W'($urandom);
            s.random_slot    = SLOT_W'($urandom);
            s.acc_x          = ACC_W'($urandom);
            s.acc_y          = ACC_W'($urandom);
            s.acc_z          = ACC_W'($urandom);
            r = $urandom_range(99);
            if (r < 74) begin
                s.action = ACT_SAMPLE;
                // posture holds for a few windows so averages can settle
                if ($urandom_range(4 * win_eff) == 0)
                    posture = t_posture'($urandom_range(3));
                case (posture)
                    POS_UPRIGHT: begin
                        s.acc_x = rand_acc(0, 2500, $urandom_range(1));
                        s.acc_y = rand_acc(0, 2500, $urandom_range(1));
                        s.acc_z = rand_acc(big_lo, 32767, $urandom_range(1));
                    end
                    POS_FACE_DN: begin
                        s.acc_x = rand_acc(0, 2500, $urandom_range(1));
                        s.acc_z = rand_acc(0, 2500, $urandom_range(1));
                        s.acc_y = ($urandom_range(15) == 0) ? 16'sh8000
                                                            : rand_acc(big_lo, 32767, 1'b1);
                    end
                    POS_FACE_UP: begin
                        s.acc_x = rand_acc(0, 2500, $urandom_range(1));
                        s.acc_z = rand_acc(0, 2500, $urandom_range(1));
                        s.acc_y = rand_acc(big_lo, 32767, 1'b0);
                    end
                    default: ;
                endcase
                t_cursor = t_cursor + $urandom_range(2 * 32'(cfg_smp_int), 0);
            end else begin
                s.action = (r < 89) ? ACT_TICK : (r < 96) ? ACT_ACTIVITY : ACT_UNUSED;
                t_cursor = t_cursor + $urandom_range(32'(cfg_smp_int) / 4, 0);
            end
            if ($urandom_range(32) == 0)
                t_cursor = t_cursor + $urandom_range(32'h0200_0000, 0);
            // rare stray timestamps off the running clock
            s.now_ms = ($urandom_range(49) == 0) ? $urandom : t_cursor;
            push_stim(s);
        end
    endtask

    // driver: one transfer offered at a time, updated on the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid          <= 1'b0;
            in_ch.action         <= ACT_SAMPLE;
            in_ch.now_ms         <= '0;
            in_ch.acc_x          <= '0;
            in_ch.acc_y          <= '0;
            in_ch.acc_z          <= '0;
            in_ch.motion_playing <= 1'b0;
            in_ch.serial_pending <= 1'b0;
            in_ch.random_offset  <= '0;
            in_ch.random_slot    <= '0;
            out_ch.ready         <= 1'b0;
        end else begin
            if (!in_ch.valid || in_taken) begin
                if (stim_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    drv_item = stim_q.pop_front();
                    in_ch.valid          <= 1'b1;
                    in_ch.action         <= drv_item.action;
                    in_ch.now_ms         <= drv_item.now_ms;
                    in_ch.acc_x          <= drv_item.acc_x;
                    in_ch.acc_y          <= drv_item.acc_y;
                    in_ch.acc_z          <= drv_item.acc_z;
                    in_ch.motion_playing <= drv_item.motion_playing;
                    in_ch.serial_pending <= drv_item.serial_pending;
                    in_ch.random_offset  <= drv_item.random_offset;
                    in_ch.random_slot    <= drv_item.random_slot;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor: results are checked before the same edge's input is predicted
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                n_results++;
                got_req.play  = out_ch.play_valid;
                got_req.kind  = out_ch.play_kind;
                got_req.slot  = out_ch.motion_slot;
                got_req.lying = out_ch.lying;
                if (motion_req_q.size() == 0) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("result %0d arrived with nothing expected", n_results);
                end else begin
                    want_req = motion_req_q.pop_front();
                    if (got_req.play !== want_req.play || got_req.kind !== want_req.kind ||
                        got_req.slot !== want_req.slot || got_req.lying !== want_req.lying) begin
                        n_err++;
                        if (n_err <= 10)
                            $display({"result %0d mismatch: exp play=%0d kind=%0d slot=%0d ",
                                      "lying=%0d, got play=%0d kind=%0d slot=%0d lying=%0d"},
                                     n_results, want_req.play, want_req.kind, want_req.slot,
                                     want_req.lying, got_req.play, got_req.kind,
                                     got_req.slot, got_req.lying);
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                mon_item.action         = in_ch.action;
                mon_item.now_ms         = in_ch.now_ms;
                mon_item.acc_x          = in_ch.acc_x;
                mon_item.acc_y          = in_ch.acc_y;
                mon_item.acc_z          = in_ch.acc_z;
                mon_item.motion_playing = in_ch.motion_playing;
                mon_item.serial_pending = in_ch.serial_pending;
                mon_item.random_offset  = in_ch.random_offset;
                mon_item.random_slot    = in_ch.random_slot;
                motion_req_q.push_back(predict_motion_request(mon_item));
                n_accepted++;
            end
        end
        in_taken <= i_rst_n && in_ch.valid && in_ch.ready;
    end

    initial begin
        #(64'd10_000_000);
        $display("FAIL");
        $finish;
    end

    initial begin
        int unsigned drain_cycles;
        reset_posture_model();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: idle boundary, blocked samples, first random motion
        push_stim(mk_stim(ACT_UNUSED,   32'd12345, 0, 0, 0, 0, 0, 0, 0));
        push_stim(mk_stim(ACT_TICK,     32'd15000, 0, 0, 0, 0, 0, 0, 0));
        push_stim(mk_stim(ACT_SAMPLE,   32'd99,    0, 0, 0, 0, 0, 0, 0));
        push_stim(mk_stim(ACT_SAMPLE,   32'd100,   0, 0, 0, 1, 0, 0, 0));
        push_stim(mk_stim(ACT_SAMPLE,   32'd100,   0, 0, 0, 0, 1, 0, 0));
        push_stim(mk_stim(ACT_SAMPLE,   32'd100,   0, 0, 0, 0, 0, 0, 0));
        push_stim(mk_stim(ACT_TICK,     32'd15001, 0, 0, 0, 0, 0, 65535, 255));
        push_stim(mk_stim(ACT_ACTIVITY, 32'd20000, 0, 0, 0, 0, 0, 0, 0));

        // window shrunk below the pending count, full-scale negative Y at max threshold
        apply_settings(1, 1, 32767, 0, 0);
        push_stim(mk_stim(ACT_SAMPLE, 32'd200, 0, -32768, 0, 0, 0, 0, 0));
        push_stim(mk_stim(ACT_SAMPLE, 32'd201, 0, -32768, 0, 0, 0, 0, 0));
        push_stim(mk_stim(ACT_TICK,   32'd202, 0, 0, 0, 0, 0, 0, 0));
        push_stim(mk_stim(ACT_SAMPLE, 32'd203, 32767, 32767, -32768, 0, 0, 0, 0));

        // zero threshold with swapped direction mapping
        apply_settings(1, 1, 0, 0, 1);
        push_stim(mk_stim(ACT_SAMPLE, 32'd204, 0, 1, 0, 0, 0, 0, 0));
        push_stim(mk_stim(ACT_TICK,   32'd205, 0, 0, 0, 0, 0, 0, 0));
        push_stim(mk_stim(ACT_SAMPLE, 32'd206, 0, -5, 0, 0, 0, 0, 0));
        push_stim(mk_stim(ACT_TICK,   32'd207, 0, 0, 0, 0, 0, 0, 0));

        // zero window acts as one; samples keep adding while lying
        apply_settings(0, 1, 0, 0, 0);
        push_stim(mk_stim(ACT_SAMPLE, 32'd208, 1, 100, -1, 0, 0, 0, 0));
        push_stim(mk_stim(ACT_SAMPLE, 32'd209, 0, 100, 0, 0, 0, 0, 0));
        push_stim(mk_stim(ACT_TICK,   32'd210, 0, 0, 0, 0, 0, 0, 0));

        // truncating average, idle boundary at zero interval, wrapped time
        apply_settings(3, 65535, 32000, 0, 1);
        push_stim(mk_stim(ACT_SAMPLE, 32'd100000, 5, -32768, -3, 0, 0, 0, 0));
        push_stim(mk_stim(ACT_SAMPLE, 32'd200000, 5, -32768, -3, 0, 0, 0, 0));
        push_stim(mk_stim(ACT_SAMPLE, 32'd300000, 5, -32767, -3, 0, 0, 0, 0));
        push_stim(mk_stim(ACT_TICK,   32'd300001, 0, 0, 0, 0, 0, 0, 0));
        push_stim(mk_stim(ACT_TICK,   32'd300001, 0, 0, 0, 0, 0, 0, 0));
        push_stim(mk_stim(ACT_TICK,   32'd300001, 0, 0, 0, 0, 0, 0, 0));
        push_stim(mk_stim(ACT_TICK,   32'd300002, 0, 0, 0, 0, 0, 1234, 171));
        push_stim(mk_stim(ACT_TICK,   32'd5, 0, 0, 0, 0, 0, 65535, 0));
        push_stim(mk_stim(ACT_SAMPLE, 32'hFFFF_FFFF, -1, -1, -1, 0, 0, 0, 0));

        t_cursor = 32'd500000;
        for (int p = 0; p < NUM_PHASES; p++) begin
            apply_settings(PH_WIN[p], PH_SMP[p], PH_GRAV[p], PH_BASE[p], PH_SWAP[p]);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            gen_phase(PH_ITEMS[p]);
        end

        drain_cycles = 0;
        while ((n_accepted != n_queued || motion_req_q.size() != 0) &&
               drain_cycles < 200000) begin
            @(negedge i_clk);
            drain_cycles++;
        end
        if (drain_cycles >= 200000) begin
            $display("FAIL");
            $finish;
        end else begin
            repeat (150) @(posedge i_clk);
            $display("Checked %0d results over %0d register settings; %0d samples summed, %0d %s",
                     n_results, n_settings, n_smp_taken, n_lying, "lying windows.");
            $display("Requests seen: %0d get-up, %0d random idle motions; %0d mismatches.",
                     n_getup, n_random, n_err);
            if (n_err == 0)
                $display("PASS");
            else
                $display("FAIL");
            $finish;
        end
    end

endmodule
